>>> src/ptd_pkg.sv
// Shared types and constants for the trial-division primality tester.
// No dependencies; imported by ptd_ctrl, ptd_datapath and primality_trial_division.
package ptd_pkg;

    localparam int unsigned NUMBER_WIDTH_DEF = 16;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture number, divisor = 2, square = 4
        logic div_start;  // clear remainder, reload shift register
        logic div_step;   // one restoring remainder step
        logic next_div;   // divisor + 1, square updated incrementally
    } t_ptd_cmd;

    // datapath -> controller
    typedef struct packed {
        logic num_lt2;    // number is 0 or 1
        logic sq_gt_num;  // divisor squared exceeds number
        logic rem_zero;   // last remainder is zero
        logic div_last;   // current step is the final bit
    } t_ptd_sts;

endpackage

>>> src/ptd_datapath.sv
// Datapath: number, trial divisor, its square and a bit-serial remainder unit.
// Depends on ptd_pkg.
module ptd_datapath #(
    parameter int unsigned NUMBER_WIDTH = ptd_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    input  ptd_pkg::t_ptd_cmd       i_cmd,
    output ptd_pkg::t_ptd_sts       o_sts
);
    import ptd_pkg::*;

    localparam int unsigned W  = NUMBER_WIDTH;
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_num;
    logic [W-1:0]  r_div;
    logic [W:0]    r_sq;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_shf;
    logic [CW-1:0] r_cnt;

    logic [W:0]    trial;
    logic [W:0]    trial_sub;

    always_comb begin
        trial     = {r_rem, r_shf[W-1]};
        trial_sub = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_number;
            r_div <= W'(2);
            r_sq  <= (W+1)'(4);
        end else if (i_cmd.next_div) begin
            r_div <= r_div + W'(1);
            // (d+1)^2 = d^2 + 2d + 1
            r_sq  <= r_sq + {r_div, 1'b1};
        end

        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_shf <= r_num;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_div}) begin
                r_rem <= trial_sub[W-1:0];
            end else begin
                r_rem <= trial[W-1:0];
            end
            r_shf <= {r_shf[W-2:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_comb begin
        o_sts.num_lt2   = (r_num < W'(2));
        o_sts.sq_gt_num = (r_sq > {1'b0, r_num});
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.div_last  = (r_cnt == CW'(W-1));
    end

endmodule

>>> src/ptd_ctrl.sv
// Controller FSM: sequences the divisor loop and owns the output register.
// Depends on ptd_pkg.
module ptd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_is_prime,
    output ptd_pkg::t_ptd_cmd o_cmd,
    input  ptd_pkg::t_ptd_sts i_sts
);
    import ptd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EVAL,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_res;
    logic   r_out_valid;
    logic   r_out_prime;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == S_CHECK) && !i_sts.num_lt2 && !i_sts.sq_gt_num;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.next_div  = (r_state == S_EVAL) && !i_sts.rem_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // refill the output slot as a finished word leaves, else drain it
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
                r_out_prime <= r_res;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (i_sts.num_lt2) begin
                        r_res   <= 1'b0;
                        r_state <= S_FINISH;
                    end else if (i_sts.sq_gt_num) begin
                        r_res   <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (i_sts.rem_zero) begin
                        r_res   <= 1'b0;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/primality_trial_division.sv
// Trial-division primality tester: top level.
// Instantiates ptd_ctrl and ptd_datapath; depends on ptd_pkg.
// Usage
//   Input channel : i_in_valid / o_in_ready carry one word, i_number.
//   Output channel: o_out_valid / i_out_ready carry one word, o_is_prime.
//   Every input word gives exactly one output word, in order.
//   0 and 1 report not prime; 2 and 3 report prime.
// Timing
//   Divisors d = 2, 3, ... are tried while d*d <= number. Each trial runs
//   one bound check, NUMBER_WIDTH steps of the bit-serial restoring
//   remainder unit and one evaluate step; no multiplier. A prime tries k
//   divisors, the worst case at 16 bits being 65521 with k = 254. One word
//   under test at a time; o_in_ready rises the cycle after the result is
//   registered.
// Reset
//   Synchronous, active low: controller idles, output register empties.
// Stall
//   A finished result sits in the output register; the next word may be
//   taken and tested meanwhile, and its result waits until the slot frees.
module primality_trial_division #(
    parameter int unsigned NUMBER_WIDTH = ptd_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_is_prime
);
    import ptd_pkg::*;

    t_ptd_cmd cmd;
    t_ptd_sts sts;

    ptd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_is_prime  (o_is_prime),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ptd_datapath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_number (i_number),
        .i_cmd    (cmd),
        .o_sts    (sts)
    );

    // an accepted word keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready straight after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_is_prime)))
        else $error("stalled result changed");

    // the remainder unit never runs while the input is open
    a_no_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(cmd.div_step || cmd.next_div))
        else $error("datapath busy while idle");

    // nothing is presented in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule
